@@ rtl/egbw_pkg.sv @@
// Exp-Golomb bit writer: shared types and constants.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package egbw_pkg;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned VAL_W   = 33;
  localparam int unsigned BLEN_W  = 6;
  localparam int unsigned RANGE_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned LG_W    = 5;
  localparam int unsigned STEP_W  = 3;

  localparam logic [ACT_W-1:0] ACT_RAW   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd4;

  localparam logic [STEP_W-1:0] LOG_LAST_STEP = 3'd4;

  typedef struct packed {
    logic              start;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } job_t;

  typedef struct packed {
    logic            done;
    logic [LG_W-1:0] lg;
  } log_stat_t;

endpackage

`default_nettype wire

@@ rtl/egbw_if.sv @@
// Exp-Golomb bit writer: input and result channel interfaces.
// Depends on egbw_pkg for field widths.
`default_nettype none

interface egbw_in_if import egbw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic signed [VAL_W-1:0]   value;
  logic [BLEN_W-1:0]         bit_length;
  logic [RANGE_W-1:0]        te_range;

  modport source (output valid, action, value, bit_length, te_range, input ready);
  modport sink   (input valid, action, value, bit_length, te_range, output ready);
endinterface

interface egbw_out_if import egbw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [BITS_W-1:0]  byte_bits;
  logic               last;

  modport source (output valid, out_byte, byte_bits, last, input ready);
  modport sink   (input valid, out_byte, byte_bits, last, output ready);
endinterface

`default_nettype wire

@@ rtl/egbw_log.sv @@
// Exp-Golomb bit writer: floor(log2 x) by binary search over five steps.
// One shared right shifter; depends on egbw_pkg.
`default_nettype none

module egbw_log import egbw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CODE_W-1:0] x,
  output log_stat_t              stat
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CODE_W-1:0] s_r, s_nxt;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic [LG_W-1:0]   sh;
  logic [CODE_W-1:0] hi;

  assign sh = LG_W'(5'd16 >> step_r);
  assign hi = s_r >> sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    s_nxt    = s_r;
    lg_nxt   = lg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      s_nxt    = x;
      lg_nxt   = '0;
    end else if (busy_r) begin
      if (hi != '0) begin
        s_nxt  = hi;
        lg_nxt = lg_r + sh;
      end
      step_nxt = step_r + 3'd1;
      if (step_r == LOG_LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    s_r  <= s_nxt;
    lg_r <= lg_nxt;
  end

  assign stat.done = done_r;
  assign stat.lg   = lg_r;

endmodule

`default_nettype wire

@@ rtl/egbw_pack.sv @@
// Exp-Golomb bit writer: byte packer with the pending-bit state and output register.
// Emits at most one byte a cycle from a right-aligned code; depends on egbw_pkg, egbw_if.
`default_nettype none

module egbw_pack import egbw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire job_t      job,
  output logic           busy,
  egbw_out_if.source     out_chan
);

  logic              busy_r, busy_nxt;
  logic              flush_r, flush_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [6:0]        pend_r, pend_nxt;
  logic [2:0]        pc_r, pc_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic [BITS_W-1:0] obits_r, obits_nxt;
  logic              olast_r, olast_nxt;

  logic              out_free;
  logic [3:0]        room;
  logic [3:0]        take;
  logic [LEN_W-1:0]  sh;
  logic [LEN_W-1:0]  after;
  logic [BYTE_W-1:0] chunk;
  logic [BYTE_W-1:0] tmask;
  logic [14:0]       acc;
  logic [3:0]        fill;
  logic [BYTE_W-1:0] fbyte;

  assign out_free = !ov_r || out_chan.ready;
  assign room     = 4'd8 - {1'b0, pc_r};
  assign take     = (rem_r < {2'b0, room}) ? rem_r[3:0] : room;
  assign sh       = rem_r - {2'b0, take};
  assign after    = sh;
  assign chunk    = BYTE_W'({32'b0, code_r} >> sh);
  assign tmask    = BYTE_W'((9'h1 << take) - 9'h1);
  assign acc      = (15'({8'b0, pend_r}) << take) | {7'b0, chunk & tmask};
  assign fill     = {1'b0, pc_r} + take;
  assign fbyte    = BYTE_W'({1'b0, pend_r} << room);

  always_comb begin
    busy_nxt  = busy_r;
    flush_nxt = flush_r;
    code_nxt  = code_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    pc_nxt    = pc_r;
    ov_nxt    = ov_r && !out_chan.ready;
    ob_nxt    = ob_r;
    obits_nxt = obits_r;
    olast_nxt = olast_r;
    if (job.start) begin
      busy_nxt  = 1'b1;
      flush_nxt = job.flush;
      code_nxt  = job.code;
      rem_nxt   = job.len;
    end else if (busy_r) begin
      if (flush_r) begin
        if (pc_r == '0) begin
          busy_nxt = 1'b0;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = fbyte;
          obits_nxt = {1'b0, pc_r};
          olast_nxt = 1'b1;
          pend_nxt  = '0;
          pc_nxt    = '0;
          busy_nxt  = 1'b0;
        end
      end else if (rem_r == '0) begin
        busy_nxt = 1'b0;
      end else if (fill == 4'd8) begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = acc[7:0];
          obits_nxt = 4'd8;
          olast_nxt = (after < 6'd8);
          pend_nxt  = '0;
          pc_nxt    = '0;
          rem_nxt   = after;
          if (after == '0) begin
            busy_nxt = 1'b0;
          end
        end
      end else begin
        pend_nxt = acc[6:0];
        pc_nxt   = fill[2:0];
        rem_nxt  = '0;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= '0;
      pc_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      pc_r   <= pc_nxt;
      ov_r   <= ov_nxt;
    end
    flush_r <= flush_nxt;
    code_r  <= code_nxt;
    rem_r   <= rem_nxt;
    ob_r    <= ob_nxt;
    obits_r <= obits_nxt;
    olast_r <= olast_nxt;
  end

  assign busy               = busy_r;
  assign out_chan.valid     = ov_r;
  assign out_chan.out_byte  = ob_r;
  assign out_chan.byte_bits = obits_r;
  assign out_chan.last      = olast_r;

endmodule

`default_nettype wire

@@ rtl/exp_golomb_bit_writer_unit.sv @@
// Exp-Golomb bit writer top level: accept sequencer, value mapping, log unit, packer.
// Depends on egbw_pkg, egbw_if, egbw_log and egbw_pack.
//
// Usage:
//   in_chan takes one beat per syntax element: action (raw, ue, se, te, flush),
//   value, bit_length and te_range. out_chan gives one beat per finished byte,
//   first written bit in the MSB, with byte_bits (8, or the pending count on
//   flush) and last on the final byte caused by the element.
//   in_chan.ready is high only while the block is idle; one element at a time.
//   raw, single-bit te and flush go to the packer at the beat; ue, se and te
//   pass a mapping state and the log search first, then hand the code to the
//   packer. The packer emits one byte a cycle while out_chan does not stall,
//   up to eight, and then parks any trailing bits. An unused action, or te with
//   range 0, writes nothing and leaves the block idle; the longest code is 63 bits.
//   Up to seven bits stay pending between elements; reset clears them.
//   A stalled out_chan holds the output register and the packer waits; the
//   block returns to idle after its last byte is loaded, even if it is not
//   yet taken.
`default_nettype none

module exp_golomb_bit_writer_unit import egbw_pkg::*; #(
  parameter int unsigned RAW_MAX_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  egbw_in_if.sink    in_chan,
  egbw_out_if.source out_chan
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAP  = 4'b0010,
    ST_LOG  = 4'b0100,
    ST_PACK = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    se_r, se_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CODE_W-1:0]       x_r, x_nxt;

  logic                    accept;
  logic [BLEN_W-1:0]       blen_eff;
  logic [CODE_W-1:0]       x_map;
  logic [VAL_W-1:0]        neg;
  job_t                    job;
  log_stat_t               lg_st;
  logic                    log_start;
  logic                    pk_busy;

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign blen_eff = (in_chan.bit_length > BLEN_W'(RAW_MAX_BITS)) ?
                    BLEN_W'(RAW_MAX_BITS) : in_chan.bit_length;
  assign neg      = VAL_W'(-val_r);

  always_comb begin
    if (se_r) begin
      if (val_r > 33'sd1073741824) begin
        x_map = 32'h8000_0000;
      end else if (val_r > 33'sd0) begin
        x_map = {val_r[30:0], 1'b0};
      end else if (val_r < -33'sd1073741823) begin
        x_map = 32'h7FFF_FFFF;
      end else begin
        x_map = {neg[30:0], 1'b1};
      end
    end else begin
      if (val_r[VAL_W-1]) begin
        x_map = 32'h0000_0001;
      end else if (val_r > 33'sd2147483647) begin
        x_map = 32'h8000_0000;
      end else begin
        x_map = val_r[CODE_W-1:0] + 32'd1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    se_nxt    = se_r;
    val_nxt   = val_r;
    x_nxt     = x_r;
    log_start = 1'b0;
    job       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt = in_chan.value;
          case (in_chan.action)
            ACT_RAW: begin
              job.start = 1'b1;
              job.code  = CODE_W'(in_chan.value[RAW_MAX_BITS-1:0]);
              job.len   = blen_eff;
              state_nxt = ST_PACK;
            end
            ACT_UE: begin
              se_nxt    = 1'b0;
              state_nxt = ST_MAP;
            end
            ACT_SE: begin
              se_nxt    = 1'b1;
              state_nxt = ST_MAP;
            end
            ACT_TE: begin
              if (in_chan.te_range > 32'd1) begin
                se_nxt    = 1'b0;
                state_nxt = ST_MAP;
              end else if (in_chan.te_range == 32'd1) begin
                job.start = 1'b1;
                job.code  = CODE_W'(~in_chan.value[0]);
                job.len   = 6'd1;
                state_nxt = ST_PACK;
              end
            end
            ACT_FLUSH: begin
              job.start = 1'b1;
              job.flush = 1'b1;
              state_nxt = ST_PACK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MAP: begin
        x_nxt     = x_map;
        log_start = 1'b1;
        state_nxt = ST_LOG;
      end
      ST_LOG: begin
        if (lg_st.done) begin
          job.start = 1'b1;
          job.code  = x_r;
          job.len   = {lg_st.lg, 1'b1};
          state_nxt = ST_PACK;
        end
      end
      ST_PACK: begin
        if (!pk_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    se_r  <= se_nxt;
    val_r <= val_nxt;
    x_r   <= x_nxt;
  end

  egbw_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (x_map),
    .stat  (lg_st)
  );

  egbw_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .busy     (pk_busy),
    .out_chan (out_chan)
  );

  a_job_state: assert property (@(posedge clk) disable iff (!rst_n)
    job.start |-> (state_r == ST_IDLE || state_r == ST_LOG))
    else $error("packer job issued outside idle or log phase");

  a_pack_state: assert property (@(posedge clk) disable iff (!rst_n)
    pk_busy |-> (state_r == ST_PACK))
    else $error("packer busy outside pack phase");

  a_log_done: assert property (@(posedge clk) disable iff (!rst_n)
    lg_st.done |-> (state_r == ST_LOG))
    else $error("log result outside log phase");

  a_map_to_log: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAP) |=> (state_r == ST_LOG))
    else $error("mapping cycle not followed by log search");

endmodule

`default_nettype wire
